[rtl/core/cfd_pkg.sv]
// Shared constants, types and CRC function for the framed byte deframer.
package cfd_pkg;

  localparam int CFD_MAX_PAYLOAD = 512;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 9;
  localparam int LEN_W       = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0]  SYNC_FIRST    = 8'h46;
  localparam logic [7:0]  SYNC_SECOND   = 8'h42;
  localparam logic [7:0]  FRAME_VERSION = 8'h01;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  localparam int HEAD_LEN  = 7;
  localparam int CHECK_LEN = 4;

  localparam int OFS_VERSION = 2;
  localparam int OFS_TYPE    = 3;
  localparam int OFS_SEQ     = 4;
  localparam int OFS_LEN_LO  = 5;
  localparam int OFS_LEN_HI  = 6;

  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic       done;
    logic [7:0] ftype;
    logic [7:0] seq;
  } cfd_frame_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_FIRST = crc_byte(CRC_INIT, SYNC_FIRST);

endpackage

[rtl/core/cfd_parser.sv]
// Frame hunt, header decode, CRC-32 check and payload write stream.
module cfd_parser import cfd_pkg::*; #(
  parameter int MAX_PAYLOAD = CFD_MAX_PAYLOAD
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                byte_en,
  input  logic [7:0]                                          rx_byte,
  output logic                                                wr_en,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
  output logic [7:0]                                          wr_data,
  output cfd_frame_t                                          frame,
  output logic [$clog2(MAX_PAYLOAD + 1)-1:0]                  frame_len
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LCNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W  = $clog2(MAX_PAYLOAD + HEAD_LEN + 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SECOND,
    PH_BODY,
    PH_CHECK
  } phase_t;

  phase_t            phase_r,   phase_nxt;
  logic [POS_W-1:0]  pos_r,     pos_nxt;
  logic [LCNT_W-1:0] exp_r,     exp_nxt;
  logic [1:0]        cnt_r,     cnt_nxt;
  logic [31:0]       crc_r,     crc_nxt;
  logic [31:0]       rcv_r,     rcv_nxt;
  logic [7:0]        type_r,    type_nxt;
  logic [7:0]        seq_r,     seq_nxt;
  logic [7:0]        ver_r,     ver_nxt;
  logic [7:0]        len_lo_r,  len_lo_nxt;

  logic        restart;
  logic        good;
  logic [15:0] len16;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    exp_nxt    = exp_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    rcv_nxt    = rcv_r;
    type_nxt   = type_r;
    seq_nxt    = seq_r;
    ver_nxt    = ver_r;
    len_lo_nxt = len_lo_r;
    restart    = 1'b0;
    good       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ADDR_W'(pos_r - POS_W'(HEAD_LEN));
    wr_data    = rx_byte;
    len16      = {rx_byte, len_lo_r};
    if (byte_en) begin
      case (phase_r)
        PH_HUNT: begin
          restart = (rx_byte == SYNC_FIRST);
        end
        PH_SECOND: begin
          if (rx_byte == SYNC_SECOND) begin
            crc_nxt   = crc_byte(crc_r, rx_byte);
            pos_nxt   = POS_W'(2);
            phase_nxt = PH_BODY;
          end else begin
            restart = 1'b1;
          end
        end
        PH_BODY: begin
          crc_nxt = crc_byte(crc_r, rx_byte);
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r < POS_W'(HEAD_LEN)) begin
            if (pos_r == POS_W'(OFS_VERSION)) begin
              ver_nxt = rx_byte;
            end else if (pos_r == POS_W'(OFS_TYPE)) begin
              type_nxt = rx_byte;
            end else if (pos_r == POS_W'(OFS_SEQ)) begin
              seq_nxt = rx_byte;
            end else if (pos_r == POS_W'(OFS_LEN_LO)) begin
              len_lo_nxt = rx_byte;
            end else if (pos_r == POS_W'(OFS_LEN_HI)) begin
              if (ver_r != FRAME_VERSION || len16 > 16'(MAX_PAYLOAD)) begin
                restart = 1'b1;
              end else begin
                exp_nxt = LCNT_W'(len16);
                if (len16 == 16'd0) begin
                  phase_nxt = PH_CHECK;
                end
              end
            end
          end else begin
            wr_en = 1'b1;
            if (pos_nxt >= POS_W'(HEAD_LEN) + POS_W'(exp_r)) begin
              phase_nxt = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          rcv_nxt = {rx_byte, rcv_r[31:8]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'(CHECK_LEN - 1)) begin
            restart = 1'b1;
            good    = ((crc_r ^ CRC_INIT) == rcv_nxt);
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (restart) begin
        pos_nxt = '0;
        exp_nxt = '0;
        cnt_nxt = '0;
        rcv_nxt = '0;
        crc_nxt = CRC_INIT;
        if (!good && rx_byte == SYNC_FIRST) begin
          crc_nxt   = CRC_FIRST;
          pos_nxt   = POS_W'(1);
          phase_nxt = PH_SECOND;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      pos_r    <= '0;
      exp_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      rcv_r    <= '0;
      type_r   <= '0;
      seq_r    <= '0;
      ver_r    <= '0;
      len_lo_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      exp_r    <= exp_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      rcv_r    <= rcv_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      ver_r    <= ver_nxt;
      len_lo_r <= len_lo_nxt;
    end
  end

  assign frame.done  = good;
  assign frame.ftype = type_r;
  assign frame.seq   = seq_r;
  assign frame_len   = exp_r;

endmodule

[rtl/core/crc32_framed_byte_deframer.sv]
// Top level of the framed byte deframer: parser, ping-pong payload store, output register.
//
//   channel | dir | tdata (low bit up)                               | tuser
//   in_     | in  | rx_byte[7:0] read_index[16:8]                    | command
//   out_    | out | frame_type[7:0] frame_sequence[15:8]            | result_kind
//           |     | frame_length[25:16] read_data[33:26]             |
//
// One item per cycle while the output is not stalled; a result is held in the staging register,
// beside the registered read of the payload store, and then in the output register.
// Payload bytes go to one bank of the store; a good frame swaps banks, so delivery needs
// no copy. rst_n is synchronous; the stores are not cleared.
// A stalled output register holds its result; input transfers stop once the staging
// register behind it also holds a result.
module crc32_framed_byte_deframer import cfd_pkg::*; #(
  parameter int MAX_PAYLOAD = CFD_MAX_PAYLOAD
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte, read_index
  input  logic                   in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // frame_type, frame_sequence, frame_length, read_data
  output logic                   out_tuser   // result_kind
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LCNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W  = ((LCNT_W > IDX_W) ? LCNT_W : IDX_W) + 1;
  localparam int PAD_W  = OUT_TDATA_W - (3 * BYTE_W + LEN_W);

  logic [7:0]       rx_byte;
  logic [IDX_W-1:0] read_index;
  logic             in_xfer;
  logic             byte_en;
  logic             rd_cmd;
  logic             rd_hit;
  logic             mem_re;
  logic             s1_adv;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  cfd_frame_t        frame;
  logic [LCNT_W-1:0] frame_len;

  logic [7:0] store_mem [0:1][0:MAX_PAYLOAD-1];
  logic [7:0] mem_rdata_r;

  logic              bank_r;
  logic [LCNT_W-1:0] dlen_r;

  logic              s1_valid_r;
  logic              s1_kind_r;
  logic              s1_hit_r;
  logic [7:0]        s1_type_r;
  logic [7:0]        s1_seq_r;
  logic [LEN_W-1:0]  s1_len_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [7:0]        out_type_r;
  logic [7:0]        out_seq_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [7:0]        out_data_r;

  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[8 +: IDX_W];

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign rd_cmd    = (in_tuser == CMD_READ);
  assign byte_en   = in_xfer && (in_tuser == CMD_RX_BYTE);
  assign rd_hit    = (CMP_W'(read_index) < CMP_W'(dlen_r)) &&
                     (CMP_W'(read_index) < CMP_W'(MAX_PAYLOAD));
  assign mem_re    = in_xfer && rd_cmd && rd_hit;

  cfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .frame     (frame),
    .frame_len (frame_len)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[~bank_r][wr_addr] <= wr_data;
    end
    if (mem_re) begin
      mem_rdata_r <= store_mem[bank_r][ADDR_W'(read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      dlen_r <= '0;
    end else if (frame.done) begin
      bank_r <= ~bank_r;
      dlen_r <= frame_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_xfer && (rd_cmd || frame.done);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= rd_cmd ? KIND_READ : KIND_FRAME;
      s1_hit_r  <= rd_hit;
      s1_type_r <= rd_cmd ? 8'd0 : frame.ftype;
      s1_seq_r  <= rd_cmd ? 8'd0 : frame.seq;
      s1_len_r  <= rd_cmd ? '0 : LEN_W'(frame_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_kind_r <= s1_kind_r;
      out_type_r <= s1_type_r;
      out_seq_r  <= s1_seq_r;
      out_len_r  <= s1_len_r;
      out_data_r <= (s1_kind_r == KIND_READ && s1_hit_r) ? mem_rdata_r : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_data_r, out_len_r, out_seq_r, out_type_r};

`ifndef SYNTHESIS
  a_read_no_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_READ |-> out_tdata[25:0] == 26'd0)
    else $error("read result carries frame fields");

  a_frame_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FRAME |-> out_tdata[33:26] == 8'd0)
    else $error("frame result carries read data");

  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> bank_r != $past(bank_r))
    else $error("good frame did not swap store banks");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !mem_re)
    else $error("store written and read in the same cycle");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_kind_r) && $stable(s1_len_r))
    else $error("staged result lost while output stalled");
`endif

endmodule
